// ===== rtl/sbe_pkg.sv =====
`default_nettype none
package sbe_pkg;

  // active modes of the tensor; the coordinate ports always carry three
  localparam int NUM_MODES = 3;
  localparam int MAX_MODES = 3;

  localparam int COORD_W   = 32;
  localparam int ELEM_W    = 8;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [3:0] BLOCK_BITS_RST  = 4'd7;
  localparam logic [4:0] KERNEL_BITS_RST = 5'd20;
  localparam logic [4:0] CHUNK_BITS_RST  = 5'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BITS  = 2'd0,
    CFG_KERNEL_BITS = 2'd1,
    CFG_CHUNK_BITS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [3:0] block_bits;
    logic [4:0] kernel_bits;
    logic [4:0] chunk_bits;
  } cfg_t;

  typedef struct packed {
    logic [MAX_MODES-1:0][COORD_W-1:0] coord;
    logic [COORD_W-1:0]                value;
  } nz_item_t;

  typedef struct packed {
    logic [MAX_MODES-1:0][ELEM_W-1:0]  elem;
    logic [COORD_W-1:0]                value;
    logic                              new_block;
    logic [CNT_W-1:0]                  block_number;
    logic [MAX_MODES-1:0][COORD_W-1:0] blk;
    logic [CNT_W-1:0]                  nz_position;
    logic [1:0]                        chunk_marks;
    logic                              new_kernel;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sbe_in_stage.sv =====
`default_nettype none
module sbe_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire sbe_pkg::nz_item_t up_item,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output sbe_pkg::nz_item_t      dn_item
);
  import sbe_pkg::*;

  logic     valid;
  logic     valid_next;
  nz_item_t item;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_comb begin
    if (up_valid && up_ready) begin
      valid_next = 1'b1;
    end else if (dn_ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // unused modes are forced to zero so they never flag a change
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item.value <= up_item.value;
      for (int m = 0; m < MAX_MODES; m++) begin
        item.coord[m] <= (m < NUM_MODES) ? up_item.coord[m] : '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbe_core.sv =====
`default_nettype none
module sbe_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sbe_pkg::cfg_t     cfg,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire sbe_pkg::nz_item_t item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output sbe_pkg::result_t       res
);
  import sbe_pkg::*;

  logic [MAX_MODES-1:0][COORD_W-1:0] prior_block;
  logic [MAX_MODES-1:0][COORD_W-1:0] prior_kernel;
  logic [CNT_W-1:0] nz_count;
  logic [CNT_W-1:0] block_count;
  logic [CNT_W-1:0] block_fill;
  logic [CNT_W-1:0] chunk_fill;
  logic             started;

  logic [MAX_MODES-1:0][COORD_W-1:0] prior_block_next;
  logic [MAX_MODES-1:0][COORD_W-1:0] prior_kernel_next;
  logic [CNT_W-1:0] block_count_next;
  logic [CNT_W-1:0] block_fill_next;
  logic [CNT_W-1:0] chunk_fill_next;

  logic [MAX_MODES-1:0][COORD_W-1:0] blk;
  logic [MAX_MODES-1:0][COORD_W-1:0] ker;
  logic [ELEM_W-1:0] emask;
  logic [CNT_W:0]    threshold;
  logic [CNT_W:0]    fill_sum;
  logic [CNT_W-1:0]  chunk_base;
  logic              blk_changed;
  logic              ker_changed;
  logic              new_block;
  logic              new_kernel;
  logic [1:0]        marks;
  logic              advance;
  result_t           res_next;

  assign item_ready = !res_valid || res_ready;
  assign advance    = item_valid && item_ready;

  always_comb begin
    for (int m = 0; m < MAX_MODES; m++) begin
      blk[m] = item.coord[m] >> cfg.block_bits;
      ker[m] = item.coord[m] >> cfg.kernel_bits;
    end
    emask       = ~({ELEM_W{1'b1}} << cfg.block_bits);
    threshold   = (CNT_W+1)'(1) << cfg.chunk_bits;
    blk_changed = (blk != prior_block);
    ker_changed = (ker != prior_kernel);
  end

  // kernel start clears the chunk fill before the closing block is judged
  always_comb begin
    prior_block_next  = prior_block;
    prior_kernel_next = prior_kernel;
    block_count_next  = block_count;
    block_fill_next   = block_fill;
    chunk_base        = ker_changed ? '0 : chunk_fill;
    fill_sum          = {1'b0, chunk_base} + {1'b0, block_fill};
    chunk_fill_next   = chunk_fill;
    new_block         = 1'b0;
    new_kernel        = 1'b0;
    marks             = 2'd0;
    if (!started) begin
      new_block         = 1'b1;
      new_kernel        = 1'b1;
      marks             = 2'd1;
      chunk_fill_next   = '0;
      block_fill_next   = CNT_W'(1);
      prior_block_next  = blk;
      prior_kernel_next = ker;
    end else begin
      if (ker_changed) begin
        new_kernel        = 1'b1;
        marks             = 2'd1;
        prior_kernel_next = ker;
      end
      chunk_fill_next = chunk_base;
      if (blk_changed) begin
        new_block = 1'b1;
        if (fill_sum >= threshold) begin
          marks           = marks + 2'd1;
          chunk_fill_next = '0;
        end else begin
          chunk_fill_next = fill_sum[CNT_W] ? '1 : fill_sum[CNT_W-1:0];
        end
        block_count_next = sat_inc(block_count);
        block_fill_next  = CNT_W'(1);
        prior_block_next = blk;
      end else begin
        block_fill_next = sat_inc(block_fill);
      end
    end
  end

  always_comb begin
    for (int m = 0; m < MAX_MODES; m++) begin
      res_next.elem[m] = item.coord[m][ELEM_W-1:0] & emask;
    end
    res_next.value        = item.value;
    res_next.new_block    = new_block;
    res_next.block_number = block_count_next - CNT_W'(1);
    res_next.blk          = blk;
    res_next.nz_position  = nz_count;
    res_next.chunk_marks  = marks;
    res_next.new_kernel   = new_kernel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_block  <= '0;
      prior_kernel <= '0;
      nz_count     <= '0;
      block_count  <= CNT_W'(1);
      block_fill   <= '0;
      chunk_fill   <= '0;
      started      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (advance) begin
        prior_block  <= prior_block_next;
        prior_kernel <= prior_kernel_next;
        nz_count     <= sat_inc(nz_count);
        block_count  <= block_count_next;
        block_fill   <= block_fill_next;
        chunk_fill   <= chunk_fill_next;
        started      <= 1'b1;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  a_kernel_marks: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.new_kernel |-> res.chunk_marks != 2'd0)
    else $error("kernel start without a chunk mark");

  a_double_mark: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.chunk_marks == 2'd2 |-> res.new_block && res.new_kernel)
    else $error("two chunk marks without a block and kernel start");

  a_nz_count: assert property (@(posedge clk) disable iff (rst)
    advance && nz_count != '1 |=> nz_count == $past(nz_count) + CNT_W'(1))
    else $error("nonzero count missed a transaction");

  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    !started |-> nz_count == '0 && block_count == CNT_W'(1) && !res_valid)
    else $error("state moved before the first transaction");

endmodule
`default_nettype wire

// ===== rtl/sparse_tensor_block_encoder.sv =====
`default_nettype none
// Streaming block encoder for a sorted 3-mode coordinate tensor. Each nonzero
// transaction on the input channel yields exactly one result transaction with
// block coordinates, offsets inside the block, the value, new block and new
// kernel flags, block number, nonzero position and chunk marks. One nonzero
// is taken every clock cycle unless the result is stalled; it passes the input
// register, then the result register, and the per-item shift, compare and fill
// add form the state update loop. Configuration writes (block_bits, kernel_bits,
// chunk_bits at indexes 0..2, other indexes ignored) take effect on the next
// cycle and must only be issued while no transaction is in flight.
module sparse_tensor_block_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sbe_pkg::COORD_W-1:0]   coord_0,
  input  wire logic [sbe_pkg::COORD_W-1:0]   coord_1,
  input  wire logic [sbe_pkg::COORD_W-1:0]   coord_2,
  input  wire logic [sbe_pkg::COORD_W-1:0]   nz_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sbe_pkg::ELEM_W-1:0]         elem_0,
  output logic [sbe_pkg::ELEM_W-1:0]         elem_1,
  output logic [sbe_pkg::ELEM_W-1:0]         elem_2,
  output logic [sbe_pkg::COORD_W-1:0]        out_value,
  output logic                               new_block,
  output logic [sbe_pkg::CNT_W-1:0]          block_number,
  output logic [sbe_pkg::COORD_W-1:0]        block_0,
  output logic [sbe_pkg::COORD_W-1:0]        block_1,
  output logic [sbe_pkg::COORD_W-1:0]        block_2,
  output logic [sbe_pkg::CNT_W-1:0]          nz_position,
  output logic [1:0]                         chunk_marks,
  output logic                               new_kernel,
  input  wire logic                          cfg_write,
  input  wire logic [sbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbe_pkg::CFG_DAT_W-1:0] cfg_data
);
  import sbe_pkg::*;

  cfg_t     cfg;
  nz_item_t in_item;
  nz_item_t st_item;
  logic     st_valid;
  logic     st_ready;
  result_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_bits  <= BLOCK_BITS_RST;
      cfg.kernel_bits <= KERNEL_BITS_RST;
      cfg.chunk_bits  <= CHUNK_BITS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLOCK_BITS:  cfg.block_bits  <= cfg_data[3:0];
        CFG_KERNEL_BITS: cfg.kernel_bits <= cfg_data;
        CFG_CHUNK_BITS:  cfg.chunk_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.coord[0] = coord_0;
  assign in_item.coord[1] = coord_1;
  assign in_item.coord[2] = coord_2;
  assign in_item.value    = nz_value;

  sbe_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (st_valid),
    .dn_ready (st_ready),
    .dn_item  (st_item)
  );

  sbe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (st_valid),
    .item_ready (st_ready),
    .item       (st_item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign elem_0       = res.elem[0];
  assign elem_1       = res.elem[1];
  assign elem_2       = res.elem[2];
  assign out_value    = res.value;
  assign new_block    = res.new_block;
  assign block_number = res.block_number;
  assign block_0      = res.blk[0];
  assign block_1      = res.blk[1];
  assign block_2      = res.blk[2];
  assign nz_position  = res.nz_position;
  assign chunk_marks  = res.chunk_marks;
  assign new_kernel   = res.new_kernel;

endmodule
`default_nettype wire
